// ----- rtl/core/feba_pkg.sv -----
// Package for the free extent block allocator.
// Holds table geometry, operation codes and the controller state type.
// Used by the top level free_extent_block_allocator, the user of feba_ram.
package feba_pkg;

  localparam int BLOCKS  = 4096;
  localparam int ADDR_W  = 12;
  localparam int LEN_W   = 12;
  localparam int ENTRY_W = LEN_W + ADDR_W;
  localparam int VOL_W   = 13;

  localparam logic [ADDR_W-1:0] COUNT_MAX      = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] LAST_BLOCK     = ADDR_W'(BLOCKS - 1);
  localparam logic [ADDR_W-1:0] FIRST_RUN_BLK  = ADDR_W'(1);
  localparam logic [VOL_W-1:0]  VOL_LIMIT      = VOL_W'(BLOCKS);

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_FORMAT = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_WALK,
    ST_LINK,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/free_extent_block_allocator.sv -----
// Top level of the free extent block allocator.
// Depends on feba_pkg and on feba_ram for the run table.
//
// The block keeps an address-ordered list of free runs for one volume of up
// to 4096 blocks, block 0 reserved. A command word enters on the s_ channel:
// s_tuser carries the mode (allocate, free, format) and s_tdata the block to
// free. Each command gives exactly one result word on the m_ channel with the
// block number, a success flag on m_tuser and the free count after the command.
// cfg_we and cfg_wdata set the volume size; users must write it only when idle.
//
// Commands are handled one at a time. Allocate reads the head run entry from
// the table, then updates and writes it back unless the run is used up. Format
// and a free that needs no list search go straight to the result. A free behind
// the head walks the list, one table read per run passed, paced by the table's
// single registered read port. The result sits in an output register, so a new
// command is accepted while a result is still held by a stalled receiver; only
// the delivery of the next result waits for it. Reset empties the list and sets
// the volume size to 4096. The table itself is not cleared; only entries that
// were written are read.
module free_extent_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,     // volume_blocks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // block[11:0], zero pad[15:12]
  input  logic [1:0]  s_tuser,       // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,       // block_res[11:0], free_count[23:12]
  output logic        m_tuser        // ok[0]
);

  localparam int AW = feba_pkg::ADDR_W;
  localparam int LW = feba_pkg::LEN_W;

  feba_pkg::state_t state, state_next;

  logic [feba_pkg::VOL_W-1:0] volume_blocks;
  logic [AW-1:0] first_free, first_free_next;
  logic [AW-1:0] free_total, free_total_next;
  logic [1:0]    op_mode;
  logic [AW-1:0] op_block;
  logic [AW-1:0] walk_addr, walk_addr_next;
  logic [AW-1:0] steps, steps_next;
  logic [AW-1:0] link, link_next;
  logic [AW-1:0] res_block, res_block_next;
  logic          res_ok, res_ok_next;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [feba_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic          accept;
  logic          out_free;
  logic [1:0]    in_mode;
  logic [AW-1:0] in_block;
  logic [feba_pkg::VOL_W-1:0] vb;
  logic          alloc_go, free_ok, free_walk, walk_more;
  logic [LW-1:0] rd_len;
  logic [AW-1:0] rd_next;

  assign s_tready = (state == feba_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_mode  = s_tuser;
  assign in_block = s_tdata[AW-1:0];
  assign rd_len   = mem_rdata[feba_pkg::ENTRY_W-1:AW];
  assign rd_next  = mem_rdata[AW-1:0];

  assign vb = (volume_blocks > feba_pkg::VOL_LIMIT) ? feba_pkg::VOL_LIMIT : volume_blocks;
  assign alloc_go  = (first_free != '0) && (free_total != '0);
  assign free_ok   = (in_block != '0) && (free_total != feba_pkg::COUNT_MAX);
  assign free_walk = (free_total != '0) && (first_free < in_block);
  assign walk_more = (rd_next < op_block) && (rd_next != '0) && (steps != feba_pkg::LAST_BLOCK);

  feba_ram #(
    .DEPTH (feba_pkg::BLOCKS),
    .WIDTH (feba_pkg::ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      feba_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = feba_pkg::ST_DONE;
          if (in_mode == feba_pkg::MODE_ALLOC && alloc_go) begin
            state_next = feba_pkg::ST_ALLOC;
          end else if (in_mode == feba_pkg::MODE_FREE && free_ok && free_walk) begin
            state_next = (first_free != '0) ? feba_pkg::ST_WALK : feba_pkg::ST_LINK;
          end
        end
      end
      feba_pkg::ST_ALLOC: begin
        state_next = feba_pkg::ST_DONE;
      end
      feba_pkg::ST_WALK: begin
        if (!walk_more) begin
          state_next = feba_pkg::ST_LINK;
        end
      end
      feba_pkg::ST_LINK: begin
        state_next = feba_pkg::ST_DONE;
      end
      feba_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = feba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = feba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = first_free;
    first_free_next = first_free;
    free_total_next = free_total;
    walk_addr_next  = walk_addr;
    steps_next      = steps;
    link_next       = link;
    res_block_next  = res_block;
    res_ok_next     = res_ok;
    unique case (state)
      feba_pkg::ST_IDLE: begin
        if (accept) begin
          res_block_next = '0;
          res_ok_next    = 1'b0;
          case (in_mode)
            feba_pkg::MODE_ALLOC: begin
              mem_re = 1'b1;
            end
            feba_pkg::MODE_FREE: begin
              res_block_next = in_block;
              if (free_ok) begin
                if (free_total == '0) begin
                  mem_we          = 1'b1;
                  mem_waddr       = in_block;
                  mem_wdata       = {LW'(1), AW'(0)};
                  first_free_next = in_block;
                  free_total_next = free_total + AW'(1);
                  res_ok_next     = 1'b1;
                end else if (free_walk) begin
                  if (first_free != '0) begin
                    mem_re         = 1'b1;
                    walk_addr_next = first_free;
                    steps_next     = '0;
                  end else begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = {LW'(0), in_block};
                    link_next = '0;
                  end
                end else begin
                  mem_we          = 1'b1;
                  mem_waddr       = in_block;
                  mem_wdata       = {LW'(1), first_free};
                  first_free_next = in_block;
                  free_total_next = free_total + AW'(1);
                  res_ok_next     = 1'b1;
                end
              end
            end
            feba_pkg::MODE_FORMAT: begin
              if (vb > feba_pkg::VOL_W'(1)) begin
                mem_we          = 1'b1;
                mem_waddr       = feba_pkg::FIRST_RUN_BLK;
                mem_wdata       = {LW'(vb - feba_pkg::VOL_W'(1)), AW'(0)};
                first_free_next = feba_pkg::FIRST_RUN_BLK;
                free_total_next = AW'(vb - feba_pkg::VOL_W'(1));
                res_ok_next     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      feba_pkg::ST_ALLOC: begin
        if (rd_len == LW'(1) || first_free == feba_pkg::LAST_BLOCK) begin
          first_free_next = rd_next;
        end else begin
          first_free_next = first_free + AW'(1);
          mem_we          = 1'b1;
          mem_waddr       = first_free + AW'(1);
          mem_wdata       = {rd_len - LW'(1), rd_next};
        end
        free_total_next = free_total - AW'(1);
        res_block_next  = first_free;
        res_ok_next     = 1'b1;
      end
      feba_pkg::ST_WALK: begin
        if (walk_more) begin
          mem_re         = 1'b1;
          mem_raddr      = rd_next;
          walk_addr_next = rd_next;
          steps_next     = steps + AW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = walk_addr;
          mem_wdata = {rd_len, op_block};
          link_next = rd_next;
        end
      end
      feba_pkg::ST_LINK: begin
        mem_we          = 1'b1;
        mem_waddr       = op_block;
        mem_wdata       = {LW'(1), link};
        free_total_next = free_total + AW'(1);
        res_ok_next     = 1'b1;
      end
      feba_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= feba_pkg::ST_IDLE;
      volume_blocks <= feba_pkg::VOL_LIMIT;
      first_free    <= '0;
      free_total    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state      <= state_next;
      first_free <= first_free_next;
      free_total <= free_total_next;
      if (cfg_we) begin
        volume_blocks <= cfg_wdata;
      end
      if (state == feba_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= in_mode;
      op_block <= in_block;
    end
    walk_addr <= walk_addr_next;
    steps     <= steps_next;
    link      <= link_next;
    res_block <= res_block_next;
    res_ok    <= res_ok_next;
    if (state == feba_pkg::ST_DONE && out_free) begin
      m_tdata <= {free_total, res_block};
      m_tuser <= res_ok && (op_mode != feba_pkg::MODE_NONE);
    end
  end

endmodule

// ----- rtl/core/feba_ram.sv -----
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; used by the allocator for the run table. No package dependency.
module feba_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
